// File: sv/q2e_pkg.sv
// Package for the quaternion to Euler angle unit.
// Holds the fixed-point widths, angle constants, the arctangent table and the side-band structs.
// Used by every module of the block.
`default_nettype none

package q2e_pkg;

  // Width of the sums of products and of the atan2 operands (Q.28).
  localparam int unsigned SumW = 34;
  // Width of the CORDIC vector registers, with headroom for the gain.
  localparam int unsigned VecW = 38;
  // Width of the Q.30 angle accumulator.
  localparam int unsigned AngW = 35;
  // Width of the operand of the square root (Q.56) and of its root (Q.28).
  localparam int unsigned RadW  = 57;
  localparam int unsigned RootW = 29;

  localparam logic signed [AngW-1:0] PiQ30 = 35'sd3373259426;
  localparam logic signed [SumW-1:0] OneQ28 = 34'sd268435456;
  localparam logic signed [18:0] PiQ13  = 19'sd25736;
  localparam logic signed [18:0] Pi2Q13 = 19'sd12868;

  // atan(2^-i) in Q.30, truncated.
  function automatic logic signed [AngW-1:0] atan_entry(input int unsigned i);
    logic signed [AngW-1:0] r;
    r = '0;
    case (i)
      0:  r = 35'sh03243F6A8;
      1:  r = 35'sh01DAC6705;
      2:  r = 35'sh00FADBAFC;
      3:  r = 35'sh007F56EA6;
      4:  r = 35'sh003FEAB76;
      5:  r = 35'sh001FFD55B;
      6:  r = 35'sh000FFFAAA;
      7:  r = 35'sh0007FFF55;
      8:  r = 35'sh0003FFFEA;
      9:  r = 35'sh0001FFFFD;
      10: r = 35'sh0000FFFFF;
      11: r = 35'sh00007FFFF;
      12: r = 35'sh00003FFFF;
      13: r = 35'sh00001FFFF;
      14: r = 35'sh00000FFFF;
      15: r = 35'sh000007FFF;
      16: r = 35'sh000003FFF;
      17: r = 35'sh000001FFF;
      18: r = 35'sh000000FFF;
      19: r = 35'sh0000007FF;
      20: r = 35'sh0000003FF;
      21: r = 35'sh0000001FF;
      22: r = 35'sh0000000FF;
      23: r = 35'sh00000007F;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Operands and sinp of one beat, carried alongside the square root.
  typedef struct packed {
    logic signed [SumW-1:0] roll_y;
    logic signed [SumW-1:0] roll_x;
    logic signed [SumW-1:0] yaw_y;
    logic signed [SumW-1:0] yaw_x;
    logic signed [SumW-1:0] sinp;
  } side_t;

  // Pitch status carried alongside the pitch CORDIC.
  typedef struct packed {
    logic clamp;
    logic neg;
  } pstat_t;

endpackage

`default_nettype wire

// File: sv/q2e_isqrt.sv
// Pipelined floor integer square root, one result bit per stage.
// Depends on q2e_pkg for the operand and root widths.
`default_nettype none

module q2e_isqrt
  import q2e_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [RadW-1:0]  rad_i,
  output logic      [RootW-1:0] root_o
);

  localparam int unsigned Steps = RootW;

  logic [RadW-1:0] rem_q  [Steps];
  logic [RadW:0]   root_q [Steps];

  // Stage k tries the bit weight 4^(Steps-1-k) against the remainder.
  for (genvar k = 0; k < Steps; k++) begin : g_stage
    localparam logic [RadW+1:0] Bit = (RadW+2)'(1) << (2 * (Steps - 1 - k));
    logic [RadW-1:0] rem_in;
    logic [RadW:0]   root_in;
    logic [RadW+1:0] trial;
    logic [RadW-1:0] rem_d;
    logic [RadW:0]   root_d;

    if (k == 0) begin : g_first
      assign rem_in  = rad_i;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    always_comb begin
      trial = {1'b0, root_in} + Bit;
      if ({2'b00, rem_in} >= trial) begin
        rem_d  = rem_in - trial[RadW-1:0];
        root_d = (root_in >> 1) + Bit[RadW:0];
      end else begin
        rem_d  = rem_in;
        root_d = root_in >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
      end
    end
  end

  assign root_o = root_q[Steps-1][RootW-1:0];

endmodule

`default_nettype wire

// File: sv/q2e_cordic.sv
// Unrolled vectoring CORDIC giving atan2(y, x) in Q.30.
// One pre-rotation stage, then one register stage per iteration; uses q2e_pkg.
`default_nettype none

module q2e_cordic
  import q2e_pkg::*;
#(
  parameter int unsigned Steps = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   en_i,
  input  wire logic signed [SumW-1:0] y_i,
  input  wire logic signed [SumW-1:0] x_i,
  output logic signed [AngW-1:0]      ang_o
);

  logic signed [VecW-1:0] x_q    [Steps+1];
  logic signed [VecW-1:0] y_q    [Steps+1];
  logic signed [AngW-1:0] z_q    [Steps+1];
  logic                   zero_q [Steps+1];

  // Pre-rotation into the right half plane, with the origin flagged.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= (x_i == '0) && (y_i == '0);
      if (x_i < 0) begin
        x_q[0] <= -VecW'(x_i);
        y_q[0] <= -VecW'(y_i);
        z_q[0] <= (y_i >= 0) ? PiQ30 : -PiQ30;
      end else begin
        x_q[0] <= VecW'(x_i);
        y_q[0] <= VecW'(y_i);
        z_q[0] <= '0;
      end
    end
  end

  // One micro-rotation per stage, driving y towards zero.
  for (genvar i = 0; i < Steps; i++) begin : g_iter
    localparam logic signed [AngW-1:0] Atan = atan_entry(i);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[i+1] <= zero_q[i];
        if (y_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + Atan;
        end else begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - Atan;
        end
      end
    end
  end

  assign ang_o = zero_q[Steps] ? '0 : z_q[Steps];

endmodule

`default_nettype wire

// File: sv/quaternion_to_euler_angles_unit.sv
// Throughput: one beat per cycle; the whole pipeline advances whenever the output
// register is empty or its beat is taken, so a stall holds every stage in place.
// The square root stage chain (29 stages) and the CORDIC stages set the depth.
// Reset clears only the valid bits; the pipeline is empty afterwards.
`default_nettype none

module quaternion_to_euler_angles_unit
  import q2e_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // quat_w [15:0], quat_x [31:16], quat_y [47:32], quat_z [63:48]
  input  wire logic [63:0] s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // roll_angle [15:0], pitch_angle [30:16], yaw_angle [46:31], zero [47]
  output logic [47:0]      m_axis_tdata_o,
  // pitch_clamped [0]
  output logic             m_axis_tuser_o
);

  localparam int unsigned SideDly = 2 + RootW;
  localparam int unsigned Lat     = 3 + SideDly + 1 + CORDIC_STEPS;

  logic en;
  logic vld_q [Lat];

  assign en              = !vld_q[Lat-1] || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = vld_q[Lat-1];

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned k = 0; k < Lat; k++) vld_q[k] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= s_axis_tvalid_i;
      for (int unsigned k = 1; k < Lat; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  // Stage 1: the products of the components that the sums need.
  logic signed [15:0] qw, qx, qy, qz;
  logic signed [31:0] wx_q, yz_q, xx_q, yy_q, wz_q, xy_q, zz_q, wy_q, zx_q;

  assign qw = s_axis_tdata_i[15:0];
  assign qx = s_axis_tdata_i[31:16];
  assign qy = s_axis_tdata_i[47:32];
  assign qz = s_axis_tdata_i[63:48];

  always_ff @(posedge clk_i) begin
    if (en) begin
      wx_q <= qw * qx;
      yz_q <= qy * qz;
      xx_q <= qx * qx;
      yy_q <= qy * qy;
      wz_q <= qw * qz;
      xy_q <= qx * qy;
      zz_q <= qz * qz;
      wy_q <= qw * qy;
      zx_q <= qz * qx;
    end
  end

  // Stage 2: the atan2 operands and sinp in Q.28.
  side_t s2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_q.roll_y <= (SumW'(wx_q) + SumW'(yz_q)) <<< 1;
      s2_q.roll_x <= OneQ28 - ((SumW'(xx_q) + SumW'(yy_q)) <<< 1);
      s2_q.yaw_y  <= (SumW'(wz_q) + SumW'(xy_q)) <<< 1;
      s2_q.yaw_x  <= OneQ28 - ((SumW'(yy_q) + SumW'(zz_q)) <<< 1);
      s2_q.sinp   <= (SumW'(wy_q) - SumW'(zx_q)) <<< 1;
    end
  end

  // Stages 3 and 4: sinp squared, then 1 - sinp^2 in Q.56.
  logic [SumW-1:0] sinp_mag;
  logic [55:0]     ss_q;
  logic [RadW-1:0] rad_q;

  assign sinp_mag = s2_q.sinp[SumW-1] ? SumW'(-s2_q.sinp) : SumW'(s2_q.sinp);

  always_ff @(posedge clk_i) begin
    if (en) begin
      ss_q  <= sinp_mag[27:0] * sinp_mag[27:0];
      rad_q <= (RadW'(1) << 56) - RadW'(ss_q);
    end
  end

  // Operands wait beside the square root.
  side_t side_q [SideDly];

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= s2_q;
      for (int unsigned k = 1; k < SideDly; k++) side_q[k] <= side_q[k-1];
    end
  end

  logic [RootW-1:0] root;

  q2e_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (rad_q),
    .root_o (root)
  );

  // Three CORDICs in lockstep.
  side_t                  sd;
  logic signed [AngW-1:0] roll_ang, yaw_ang, pitch_ang;

  assign sd = side_q[SideDly-1];

  q2e_cordic #(.Steps(CORDIC_STEPS)) u_roll (
    .clk_i (clk_i), .en_i (en), .y_i (sd.roll_y), .x_i (sd.roll_x), .ang_o (roll_ang)
  );

  q2e_cordic #(.Steps(CORDIC_STEPS)) u_yaw (
    .clk_i (clk_i), .en_i (en), .y_i (sd.yaw_y), .x_i (sd.yaw_x), .ang_o (yaw_ang)
  );

  q2e_cordic #(.Steps(CORDIC_STEPS)) u_pitch (
    .clk_i (clk_i), .en_i (en), .y_i (sd.sinp), .x_i (SumW'(root)), .ang_o (pitch_ang)
  );

  // Pitch clamp status follows the CORDIC stages.
  pstat_t pst_q [CORDIC_STEPS+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      pst_q[0].clamp <= (sd.sinp >= OneQ28) || (sd.sinp <= -OneQ28);
      pst_q[0].neg   <= sd.sinp[SumW-1];
      for (int unsigned k = 1; k <= CORDIC_STEPS; k++) pst_q[k] <= pst_q[k-1];
    end
  end

  // Q.30 to Q3.13, rounded half up and clamped.
  function automatic logic signed [18:0] to_q13(input logic signed [AngW-1:0] a,
                                                input logic signed [18:0] lim);
    logic signed [AngW:0] t;
    logic signed [18:0]   r;
    t = (AngW+1)'(a) + (AngW+1)'(65536);
    r = 19'(t >>> 17);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  logic signed [18:0] roll_r, yaw_r, pitch_r;
  pstat_t             pst;

  assign pst    = pst_q[CORDIC_STEPS];
  assign roll_r = to_q13(roll_ang, PiQ13);
  assign yaw_r  = to_q13(yaw_ang, PiQ13);

  always_comb begin
    if (pst.clamp) begin
      pitch_r = pst.neg ? -Pi2Q13 : Pi2Q13;
    end else begin
      pitch_r = to_q13(pitch_ang, Pi2Q13);
    end
  end

  // Output register.
  logic [47:0] out_data_q;
  logic        out_user_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= {1'b0, yaw_r[15:0], pitch_r[14:0], roll_r[15:0]};
      out_user_q <= pst.clamp;
    end
  end

  assign m_axis_tdata_o = out_data_q;
  assign m_axis_tuser_o = out_user_q;

  // A clamped pitch is always exactly plus or minus pi/2.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |->
      (m_axis_tdata_o[30:16] == 15'sd12868 || m_axis_tdata_o[30:16] == -15'sd12868))
    else $error("clamped pitch is not pi/2");

  // Roll and yaw never leave the range of pi.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ($signed(m_axis_tdata_o[15:0]) <= 16'sd25736 &&
                         $signed(m_axis_tdata_o[15:0]) >= -16'sd25736 &&
                         $signed(m_axis_tdata_o[46:31]) <= 16'sd25736 &&
                         $signed(m_axis_tdata_o[46:31]) >= -16'sd25736))
    else $error("roll or yaw out of range");

  // A held result freezes the whole pipeline, so the input side stalls too.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> ($stable(m_axis_tdata_o) && m_axis_tvalid_o))
    else $error("result changed under stall");

endmodule

`default_nettype wire

// File: sim/quaternion_to_euler_angles_unit_test.sv
// Self-checking testbench for the quaternion to Euler angle unit.
// Drives quaternion beats, predicts roll, pitch and yaw with an integer model
// of its own, and compares every result beat. Depends on q2e_pkg and the unit.
`timescale 1ns / 100ps

module quaternion_to_euler_angles_unit_test;

  localparam int unsigned Steps = 16;
  localparam int unsigned Latency = 35 + Steps;

  // One quaternion and the angles it gives.
  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } quat_t;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
    logic               clamped;
  } euler_t;

  typedef struct {
    quat_t  q;
    bit     known;
    euler_t angles;
  } vector_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [47:0] out_data;
  logic        out_user;

  int    errors = 0;
  int    send_idle = 36;
  int    take_idle = 48;
  bit    draining = 1'b0;
  euler_t angles_due[$];

  quaternion_to_euler_angles_unit #(.CORDIC_STEPS(Steps)) u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(in_valid),
    .s_axis_tready_o(in_ready),
    .s_axis_tdata_i (in_data),
    .m_axis_tvalid_o(out_valid),
    .m_axis_tready_i(out_ready),
    .m_axis_tdata_o (out_data),
    .m_axis_tuser_o (out_user)
  );

  // Clock: 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint atan_q30(int i);
    longint t [24] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
      64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
      64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
      64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
      64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
    return t[i];
  endfunction

  // Floor square root of an unsigned 64-bit value.
  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Vectoring-mode CORDIC; operands in Q.28, angle in Q.30.
  function automatic longint vector_angle(longint y, longint x);
    longint a;
    longint xs;
    longint ys;
    a = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      a = (y >= 0) ? 64'sd3373259426 : -64'sd3373259426;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < Steps && i < 24; i++) begin
      xs = shr(x, i);
      ys = shr(y, i);
      if (y >= 0) begin
        x += ys;
        y -= xs;
        a += atan_q30(i);
      end else begin
        x -= ys;
        y += xs;
        a -= atan_q30(i);
      end
    end
    return a;
  endfunction

  // Q.30 to Q3.13 with round half up, then clamp to +-lim.
  function automatic longint round_q13(longint a, longint lim);
    longint r;
    r = shr(a + 65536, 17);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic euler_t euler_of(quat_t q);
    euler_t e;
    longint w, x, y, z, sinp, p;
    longint unsigned root;
    w = q.w;
    x = q.x;
    y = q.y;
    z = q.z;
    e.roll = 16'(round_q13(vector_angle(2 * (w * x + y * z),
                                        (64'sd1 << 28) - 2 * (x * x + y * y)), 25736));
    e.yaw = 16'(round_q13(vector_angle(2 * (w * z + x * y),
                                       (64'sd1 << 28) - 2 * (y * y + z * z)), 25736));
    sinp = 2 * (w * y - z * x);
    if (sinp >= (64'sd1 << 28) || sinp <= -(64'sd1 << 28)) begin
      p = (sinp > 0) ? 12868 : -12868;
      e.clamped = 1'b1;
    end else begin
      root = floor_sqrt((64'd1 << 56) - longint'(sinp * sinp));
      p = round_q13(vector_angle(sinp, longint'(root)), 12868);
      e.clamped = 1'b0;
    end
    e.pitch = 15'(p);
    return e;
  endfunction

  function automatic quat_t random_quat();
    quat_t q;
    int k;
    k = $urandom_range(0, 9);
    q = $urandom() ^ {$urandom(), 32'h0};
    if (k < 6) begin
      // Random quaternions: components within the Q2.14 unit range.
      q.w = 16'($urandom_range(0, 32768) - 16384);
      q.x = 16'($urandom_range(0, 32768) - 16384);
      q.y = 16'($urandom_range(0, 32768) - 16384);
      q.z = 16'($urandom_range(0, 32768) - 16384);
    end else if (k < 8) begin
      // Near gimbal lock: w*y dominates.
      q.w = 16'($urandom_range(10000, 12500));
      q.y = $urandom_range(0, 1) ? q.w : -q.w;
      q.x = 16'($urandom_range(0, 800) - 400);
      q.z = 16'($urandom_range(0, 800) - 400);
    end
    return q;
  endfunction

  // Sender: one beat per accepted quaternion, with random gaps. The valid
  // line stays high after a beat and drops only when the sender idles.
  task automatic send_beat(quat_t q);
    while (send_idle > 0 && $urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= {q.z, q.y, q.x, q.w};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    angles_due.push_back(euler_of(q));
    @(negedge clk);
  endtask

  // Receiver stalls at random.
  always @(negedge clk) begin
    out_ready <= draining || !(take_idle > 0 && $urandom_range(0, 99) < take_idle);
  end

  // Result check against the oldest expectation.
  always @(posedge clk) begin
    euler_t got;
    euler_t want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_data[15:0], out_data[30:16], out_data[46:31], out_user};
      if (angles_due.size() == 0) begin
        $display("%0t: unexpected beat %h", $time, got);
        errors++;
      end else begin
        want = angles_due.pop_front();
        if (got.roll !== want.roll) begin
          $display("%0t: roll exp %0d got %0d", $time, want.roll, got.roll);
          errors++;
        end
        if (got.pitch !== want.pitch) begin
          $display("%0t: pitch exp %0d got %0d", $time, want.pitch, got.pitch);
          errors++;
        end
        if (got.yaw !== want.yaw) begin
          $display("%0t: yaw exp %0d got %0d", $time, want.yaw, got.yaw);
          errors++;
        end
        if (got.clamped !== want.clamped) begin
          $display("%0t: clamp exp %0b got %0b", $time, want.clamped, got.clamped);
          errors++;
        end
        if (out_data[47] !== 1'b0) begin
          $display("%0t: pad bit exp 0 got %b", $time, out_data[47]);
          errors++;
        end
      end
    end
  end

  // Directed rows; typed results only where obvious.
  vector_t directed [] = '{
    '{'{16'sd16384, 16'sd0, 16'sd0, 16'sd0}, 1'b1, '{16'sd0, 15'sd0, 16'sd0, 1'b0}},
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, '{16'sd0, 15'sd0, 16'sd0, 1'b0}},
    '{'{16'sd16384, 16'sd0, 16'sd8192, 16'sd0}, 1'b1, '{16'sd0, 15'sd12868, 16'sd0, 1'b1}},
    '{'{16'sd16384, 16'sd0, -16'sd8192, 16'sd0}, 1'b1,
      '{16'sd0, -15'sd12868, 16'sd0, 1'b1}},
    '{'{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768}, 1'b0, '0},
    '{'{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767}, 1'b0, '0},
    '{'{16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768}, 1'b0, '0},
    '{'{-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767}, 1'b0, '0},
    '{'{16'sd0, 16'sd16384, 16'sd0, 16'sd0}, 1'b0, '0},
    '{'{16'sd0, 16'sd0, 16'sd16384, 16'sd0}, 1'b0, '0},
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd16384}, 1'b0, '0},
    '{'{16'sd11585, 16'sd11585, 16'sd0, 16'sd0}, 1'b0, '0},
    '{'{16'sd11585, 16'sd0, 16'sd0, 16'sd11585}, 1'b0, '0},
    '{'{16'sd0, 16'sd11585, 16'sd0, 16'sd11585}, 1'b0, '0},
    '{'{16'sd14189, 16'sd8192, 16'sd0, 16'sd0}, 1'b0, '0},
    '{'{16'sd11000, 16'sd100, 16'sd11000, -16'sd100}, 1'b0, '0},
    '{'{16'sd0, 16'sd0, 16'sd1, 16'sd0}, 1'b0, '0},
    '{'{16'sd1, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
    '{'{-16'sd1, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
    '{'{16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192}, 1'b0, '0},
    '{'{-16'sd8192, 16'sd8192, -16'sd8192, 16'sd8192}, 1'b0, '0}
  };

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    foreach (directed[i]) begin
      if (directed[i].known && euler_of(directed[i].q) !== directed[i].angles) begin
        $display("%0t: table row %0d exp %h predicted %h", $time, i,
                 directed[i].angles, euler_of(directed[i].q));
        errors++;
      end
      send_beat(directed[i].q);
    end
    // Three idling phases over the random part.
    for (int n = 0; n < 550; n++) begin
      if (n == 180) begin
        send_idle = 48;
        take_idle = 36;
      end else if (n == 370) begin
        send_idle = 0;
        take_idle = 0;
      end
      send_beat(random_quat());
    end
    in_valid <= 1'b0;
    while (angles_due.size() != 0) @(posedge clk);
    draining = 1'b1;
    repeat (Latency + 10) @(posedge clk);
    if (errors == 0) begin
      $display("** quaternion_to_euler_angles_unit: PASSED **");
    end else begin
      $display("** quaternion_to_euler_angles_unit: FAILED **");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2ms;
    $display("** quaternion_to_euler_angles_unit: FAILED **");
    $finish;
  end

endmodule

// File: quaternion_to_euler_angles_unit.f
sv/q2e_pkg.sv
sv/q2e_isqrt.sv
sv/q2e_cordic.sv
sv/quaternion_to_euler_angles_unit.sv
sim/quaternion_to_euler_angles_unit_test.sv
